// File: rtl/lpht_pkg.sv
// Shared constants and types for the linear-probe hash table core.
package lpht_pkg;

    // Table size must stay a power of two: the home slot is then the low hash bits.
    localparam int TABLE_SIZE = 128;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int NAME_BYTES = 8;
    localparam int NAME_W     = 64;
    localparam int CAT_W      = 4;
    localparam int CHAN_W     = 8;
    localparam int HASH_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 7;

    localparam logic [CAT_W-1:0] CAT_EMPTY   = 4'd0;
    localparam logic [CAT_W-1:0] CAT_DELETED = 4'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [CAT_W-1:0]  cat;
        logic [NAME_W-1:0] name;
    } t_entry;

endpackage

// File: rtl/linear_probe_hash_table_core.sv
// Linear-probe hash table core: name hash, slot probe and record write-back.
//
//  Channel | Dir | tdata (low bit up)                      | tuser
//  s_axis  | in  | key_name[63:0], category[3:0],          | mode[0]
//          |     | channel[7:0], 4 zero bits               |
//  m_axis  | out | slot[6:0], 1 zero bit                   | status[2:0]
//
//  Steps per request: accept, hash over the name bytes, probes (1 to TABLE_SIZE,
//  one entry memory read each), then write-back and result.
//  The probe loop through the single read port of the entry memory sets the rate.
//  Reset clears the per-slot valid bits at once; no clearing pass is needed.
//  A result waiting on m_axis does not block the next accept; write-back of a
//  further request holds until the output register is free.
module linear_probe_hash_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // key_name[63:0], category[67:64], channel[75:68]
    input  logic [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // slot[6:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int AW = lpht_pkg::ADDR_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;

    logic                                r_mode;
    logic [lpht_pkg::NAME_W-1:0]         r_name;
    logic [lpht_pkg::NAME_W-1:0]         r_bytes, n_bytes;
    logic [lpht_pkg::CAT_W-1:0]          r_cat;
    logic [lpht_pkg::CHAN_W-1:0]         r_chan;
    logic [lpht_pkg::HASH_W-1:0]         r_hash, n_hash;
    logic [AW-1:0]                       r_pos, n_pos;
    logic [AW-1:0]                       r_cnt, n_cnt;
    logic                                r_have_del, n_have_del;
    logic [AW-1:0]                       r_del_pos, n_del_pos;

    logic [lpht_pkg::STATUS_W-1:0]       r_res_status, n_res_status;
    logic [AW-1:0]                       r_res_slot, n_res_slot;
    logic                                r_wr_entry, n_wr_entry;
    logic                                r_wr_chan, n_wr_chan;

    logic                                r_out_valid;
    logic [lpht_pkg::STATUS_W-1:0]       r_out_status;
    logic [lpht_pkg::SLOT_W-1:0]         r_out_slot;

    lpht_pkg::t_entry                    mem_entry [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::CHAN_W-1:0]         mem_chan  [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::TABLE_SIZE-1:0]     r_valid;
    lpht_pkg::t_entry                    r_rd_entry;
    logic                                r_rd_vld;

    logic                                in_fire;
    logic                                done_fire;
    logic [7:0]                          cur_byte;
    logic [lpht_pkg::CAT_W-1:0]          rd_cat;
    logic                                hit;
    logic                                eff_have_del;
    logic [AW-1:0]                       eff_del_pos;
    logic [AW-1:0]                       pos_inc;
    logic                                stopped;
    logic                                free_stop;

    // Keep bytes up to the first zero within NAME_BYTES; zero the rest.
    function automatic logic [lpht_pkg::NAME_W-1:0] f_canon(
        input logic [lpht_pkg::NAME_W-1:0] raw
    );
        logic [lpht_pkg::NAME_W-1:0] res;
        logic                        live;
        res  = '0;
        live = 1'b1;
        for (int i = 0; i < lpht_pkg::NAME_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign done_fire     = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign cur_byte = r_bytes[7:0];
    assign rd_cat   = r_rd_vld ? r_rd_entry.cat : lpht_pkg::CAT_EMPTY;
    assign hit      = (rd_cat == lpht_pkg::CAT_EMPTY) || (r_rd_entry.name == r_name);
    assign pos_inc  = (r_pos == AW'(lpht_pkg::TABLE_SIZE - 1)) ? '0 : r_pos + 1'b1;

    // Count this slot as the first deleted one if none was seen before.
    assign eff_have_del = r_have_del || (rd_cat == lpht_pkg::CAT_DELETED);
    assign eff_del_pos  = r_have_del ? r_del_pos : r_pos;

    assign stopped   = hit;
    assign free_stop = !stopped || (rd_cat == lpht_pkg::CAT_EMPTY) ||
                       (rd_cat == lpht_pkg::CAT_DELETED);

    always_comb begin
        n_state      = r_state;
        n_bytes      = r_bytes;
        n_hash       = r_hash;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_have_del   = r_have_del;
        n_del_pos    = r_del_pos;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_wr_entry   = r_wr_entry;
        n_wr_chan    = r_wr_chan;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_bytes    = f_canon(s_axis_tdata[63:0]);
                    n_hash     = '0;
                    n_have_del = 1'b0;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (cur_byte == 8'd0) begin
                    // Power-of-two table: the non-negative remainder is the low hash bits.
                    n_pos   = r_hash[AW-1:0];
                    n_cnt   = '0;
                    n_state = S_CHECK;
                end else begin
                    n_hash  = (r_hash << 5) + {{(lpht_pkg::HASH_W-8){cur_byte[7]}}, cur_byte};
                    n_bytes = {8'd0, r_bytes[lpht_pkg::NAME_W-1:8]};
                end
            end
            S_CHECK: begin
                if (hit || (r_cnt == AW'(lpht_pkg::TABLE_SIZE - 1))) begin
                    n_wr_entry   = 1'b0;
                    n_wr_chan    = 1'b0;
                    n_res_slot   = '0;
                    if (r_mode == lpht_pkg::MODE_INSERT) begin
                        if (stopped && !free_stop) begin
                            n_res_status = lpht_pkg::ST_EXISTS;
                            n_res_slot   = r_pos;
                        end else if (eff_have_del || stopped) begin
                            n_res_status = lpht_pkg::ST_INSERTED;
                            n_res_slot   = eff_have_del ? eff_del_pos : r_pos;
                            n_wr_entry   = 1'b1;
                            n_wr_chan    = 1'b1;
                        end else begin
                            n_res_status = lpht_pkg::ST_FULL;
                        end
                    end else begin
                        if (stopped && !free_stop) begin
                            n_res_status = lpht_pkg::ST_UPDATED;
                            n_res_slot   = r_pos;
                            n_wr_chan    = 1'b1;
                        end else begin
                            n_res_status = lpht_pkg::ST_NOT_FOUND;
                        end
                    end
                    n_state = S_DONE;
                end else begin
                    n_have_del = eff_have_del;
                    n_del_pos  = eff_del_pos;
                    n_pos      = pos_inc;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_have_del  <= 1'b0;
            r_wr_entry  <= 1'b0;
            r_wr_chan   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state    <= n_state;
            r_have_del <= n_have_del;
            r_wr_entry <= n_wr_entry;
            r_wr_chan  <= n_wr_chan;
            r_cnt      <= n_cnt;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= s_axis_tuser[0];
            r_name <= f_canon(s_axis_tdata[63:0]);
            r_cat  <= s_axis_tdata[67:64];
            r_chan <= s_axis_tdata[75:68];
        end
        r_bytes      <= n_bytes;
        r_hash       <= n_hash;
        r_pos        <= n_pos;
        r_del_pos    <= n_del_pos;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        if (done_fire) begin
            r_out_status <= r_res_status;
            r_out_slot   <= lpht_pkg::SLOT_W'(r_res_slot);
        end
    end

    // Per-slot valid bits: an unwritten slot reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[n_pos];
            if (done_fire && r_wr_entry) begin
                r_valid[r_res_slot] <= 1'b1;
            end
        end
    end

    // Entry and channel stores; read data is registered and lands in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rd_entry <= mem_entry[n_pos];
        if (done_fire && r_wr_entry) begin
            mem_entry[r_res_slot] <= '{cat: r_cat, name: r_name};
        end
        if (done_fire && r_wr_chan) begin
            mem_chan[r_res_slot] <= r_chan;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_slot};
    assign m_axis_tuser  = r_out_status;

    // A full or not-found result reports slot 0.
    a_noslot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == lpht_pkg::ST_FULL ||
                           m_axis_tuser == lpht_pkg::ST_NOT_FOUND))
        |-> (m_axis_tdata == 8'd0))
        else $error("no-slot result carries a nonzero slot");

    // One request at a time: accept closes the input until write-back.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input reopened straight after accept");

    // Write-back loads the output register on the following edge.
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> (m_axis_tvalid && m_axis_tuser == $past(r_res_status)))
        else $error("result not presented after write-back");

    // Channel write without entry write happens only for an update.
    a_update_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_wr_chan && !r_wr_entry)
        |-> (r_mode == lpht_pkg::MODE_UPDATE && r_res_status == lpht_pkg::ST_UPDATED))
        else $error("channel-only write outside an update");

endmodule

// File: dv/linear_probe_hash_table_core_tb.sv
// Self-checking testbench for the linear-probe hash table core, with its own table predictor.
module linear_probe_hash_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = lpht_pkg::TABLE_SIZE;
    localparam int NAME_BYTES = lpht_pkg::NAME_BYTES;
    localparam int NAME_W     = lpht_pkg::NAME_W;
    localparam int CAT_W      = lpht_pkg::CAT_W;
    localparam int CHAN_W     = lpht_pkg::CHAN_W;
    localparam int HASH_W     = lpht_pkg::HASH_W;
    localparam int STATUS_W   = lpht_pkg::STATUS_W;
    localparam int SLOT_W     = lpht_pkg::SLOT_W;

    localparam int N_RANDOM    = 1780;
    localparam int N_CALM_TAIL = 150;
    localparam int SETTLE_CYC  = 200;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic              mode;
        logic [NAME_W-1:0] name;
        logic [CAT_W-1:0]  cat;
        logic [CHAN_W-1:0] chan;
        bit                drain;  // wait for every result before this request
        bit                calm;   // no idling from here on
    } t_req;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_resp;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata  = '0;  // key_name[63:0], category[67:64], channel[75:68]
    logic [0:0]   s_axis_tuser  = '0;  // mode[0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;        // slot[6:0]
    logic [2:0]   m_axis_tuser;        // status[2:0]

    linear_probe_hash_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predicted contents of the table
    logic [NAME_W-1:0] rec_name [TABLE_SIZE];
    logic [CAT_W-1:0]  rec_cat  [TABLE_SIZE];
    logic [CHAN_W-1:0] rec_chan [TABLE_SIZE];

    t_req              req_q[$];
    t_resp             due_q[$];
    logic [NAME_W-1:0] name_pool[$];

    int n_sent    = 0;
    int n_recv    = 0;
    int n_err     = 0;
    int idle_cyc  = 0;
    int gap_left  = 0;
    int stall_left = 0;
    bit calm_now  = 1'b0;
    t_req cur;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Keep bytes up to the first zero; clear the rest.
    function automatic logic [NAME_W-1:0] canon(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] out;
        out = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'h00) break;
            out[8*i +: 8] = raw[8*i +: 8];
        end
        return out;
    endfunction

    function automatic int home_of(input logic [NAME_W-1:0] name);
        logic [HASH_W-1:0] v;
        logic [HASH_W-1:0] mag;
        logic [7:0]        b;
        int                r;
        v = '0;
        for (int i = 0; i < 8; i++) begin
            b = name[8*i +: 8];
            if (b == 8'h00) break;
            v = (v << 5) + {{24{b[7]}}, b};
        end
        if (v[HASH_W-1]) begin
            mag = ~v + 1'b1;
            r   = int'(mag % TABLE_SIZE);
            return (r == 0) ? 0 : TABLE_SIZE - r;
        end
        return int'(v % TABLE_SIZE);
    endfunction

    // Probe for the request's name and apply it to the predicted table.
    function automatic t_resp probe_and_commit(input t_req rq);
        logic [NAME_W-1:0] name;
        int                pos;
        int                del_pos;
        int                w;
        bit                stopped;
        bit                have_del;
        bit                free_stop;
        t_resp             rs;
        name     = canon(rq.name);
        pos      = home_of(name);
        stopped  = 1'b0;
        have_del = 1'b0;
        del_pos  = 0;
        rs.slot  = '0;
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (rec_cat[pos] == lpht_pkg::CAT_EMPTY || rec_name[pos] == name) begin
                stopped = 1'b1;
                break;
            end
            if (rec_cat[pos] == lpht_pkg::CAT_DELETED && !have_del) begin
                have_del = 1'b1;
                del_pos  = pos;
            end
            pos = (pos + 1) % TABLE_SIZE;
        end
        if (rq.mode == lpht_pkg::MODE_INSERT) begin
            free_stop = !stopped || rec_cat[pos] == lpht_pkg::CAT_EMPTY ||
                        rec_cat[pos] == lpht_pkg::CAT_DELETED;
            if (stopped && !free_stop) begin
                rs.status = lpht_pkg::ST_EXISTS;
                rs.slot   = SLOT_W'(pos);
            end else if (have_del || stopped) begin
                w = have_del ? del_pos : pos;
                rec_name[w] = name;
                rec_cat[w]  = rq.cat;
                rec_chan[w] = rq.chan;
                rs.status   = lpht_pkg::ST_INSERTED;
                rs.slot     = SLOT_W'(w);
            end else begin
                rs.status = lpht_pkg::ST_FULL;
            end
        end else begin
            if (stopped && rec_cat[pos] != lpht_pkg::CAT_EMPTY &&
                rec_cat[pos] != lpht_pkg::CAT_DELETED) begin
                rec_chan[pos] = rq.chan;
                rs.status     = lpht_pkg::ST_UPDATED;
                rs.slot       = SLOT_W'(pos);
            end else begin
                rs.status = lpht_pkg::ST_NOT_FOUND;
            end
        end
        return rs;
    endfunction

    task automatic add(input logic mode, input logic [NAME_W-1:0] name,
                       input logic [CAT_W-1:0] cat, input logic [CHAN_W-1:0] chan);
        t_req rq;
        rq.mode  = mode;
        rq.name  = name;
        rq.cat   = cat;
        rq.chan  = chan;
        rq.drain = 1'b0;
        rq.calm  = 1'b0;
        req_q.push_back(rq);
    endtask

    // Two-letter name that lands on the given home slot.
    function automatic logic [NAME_W-1:0] twin_of(input int home, input logic [NAME_W-1:0] avoid);
        logic [NAME_W-1:0] nm;
        do begin
            nm = {48'h0, 8'($urandom_range(8'h61, 8'h7a)), 8'($urandom_range(8'h61, 8'h7a))};
        end while (home_of(nm) != home || nm == avoid);
        return nm;
    endfunction

    function automatic logic [NAME_W-1:0] fresh_name();
        logic [NAME_W-1:0] nm;
        int                len;
        int                kind;
        nm   = '0;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) nm[8*i +: 8] = 8'($urandom_range(8'h80, 8'hff));
                else nm[8*i +: 8] = 8'($urandom_range(8'h61, 8'h68));
            end
        end else if (kind <= 7) begin
            nm = {$urandom, $urandom};
        end else if (kind == 8) begin
            nm = {$urandom, $urandom} | 64'h8080_8080_8080_8080;
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        return nm;
    endfunction

    // Put random junk after the terminating zero byte; it must not count.
    function automatic logic [NAME_W-1:0] with_tail(input logic [NAME_W-1:0] cn);
        logic [NAME_W-1:0] nm;
        int                len;
        nm  = cn;
        len = 8;
        for (int i = 0; i < 8; i++) begin
            if (cn[8*i +: 8] == 8'h00) begin
                len = i;
                break;
            end
        end
        for (int i = len + 1; i < 8; i++) nm[8*i +: 8] = 8'($urandom);
        return nm;
    endfunction

    function automatic logic [CAT_W-1:0] pick_cat();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return lpht_pkg::CAT_DELETED;
        if (r == 2) return lpht_pkg::CAT_EMPTY;
        return CAT_W'($urandom_range(0, 15));
    endfunction

    // Request driver
    always @(posedge i_clk) begin
        t_resp rs;
        bit    done;
        bit    go;
        done = 1'b0;
        go   = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rs = probe_and_commit(cur);
                due_q.push_back(rs);
                n_sent <= n_sent + 1;
                done = 1'b1;
            end
            if (!s_axis_tvalid || done) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (req_q.size() != 0) begin
                    if (req_q[0].drain && (n_sent + int'(done)) != n_recv) begin
                        // hold until the block has drained
                    end else begin
                        req_q[0].drain = 1'b0;
                        if (!req_q[0].calm && $urandom_range(0, 5) == 0) begin
                            gap_left = $urandom_range(1, 8) - 1;
                        end else begin
                            cur = req_q.pop_front();
                            calm_now <= cur.calm;
                            go = 1'b1;
                        end
                    end
                end
                s_axis_tvalid <= go;
                if (go) begin
                    s_axis_tdata <= {4'h0, cur.chan, cur.cat, cur.name};
                    s_axis_tuser <= cur.mode;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge i_clk) begin
        t_resp w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_q.size() == 0) begin
                    $error("unexpected result: status=%0d slot=%0d",
                           m_axis_tuser, m_axis_tdata[SLOT_W-1:0]);
                    n_err++;
                end else begin
                    w = due_q.pop_front();
                    n_recv <= n_recv + 1;
                    if (m_axis_tuser !== w.status) begin
                        $error("status: expected %0d, actual %0d", w.status, m_axis_tuser);
                        n_err++;
                    end
                    if (m_axis_tdata[SLOT_W-1:0] !== w.slot) begin
                        $error("slot: expected %0d, actual %0d",
                               w.slot, m_axis_tdata[SLOT_W-1:0]);
                        n_err++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm_now && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= STALL_LIMIT) begin
                $display("linear_probe_hash_table_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [NAME_W-1:0] abc;
        logic [NAME_W-1:0] twin_a;
        logic [NAME_W-1:0] twin_b;
        logic [NAME_W-1:0] nm;
        int                r;

        for (int i = 0; i < TABLE_SIZE; i++) begin
            rec_name[i] = '0;
            rec_cat[i]  = lpht_pkg::CAT_EMPTY;
            rec_chan[i] = '0;
        end

        // Directed requests
        abc    = 64'h0000_0000_0063_6261;
        twin_a = twin_of(home_of(abc), abc);
        twin_b = twin_of(home_of(abc), twin_a);
        add(lpht_pkg::MODE_UPDATE, abc, 4'd1, 8'h11);                     // nothing there yet
        add(lpht_pkg::MODE_INSERT, abc, 4'd1, 8'h00);
        add(lpht_pkg::MODE_INSERT, abc, 4'd9, 8'h22);                     // already present
        add(lpht_pkg::MODE_UPDATE, abc, 4'd0, 8'hff);
        add(lpht_pkg::MODE_INSERT, 64'h0, 4'd15, 8'hff);                  // empty name
        add(lpht_pkg::MODE_INSERT, 64'hffff_ffff_ffff_ffff, 4'd2, 8'h5a); // negative hash
        add(lpht_pkg::MODE_INSERT, 64'h8080_8080_8080_8080, 4'd4, 8'ha5);
        add(lpht_pkg::MODE_INSERT, 64'h7f7f_7f7f_7f7f_7f7f, 4'd14, 8'h01);
        add(lpht_pkg::MODE_INSERT, 64'hdead_beef_0000_6261, 4'd5, 8'h33); // junk after end
        add(lpht_pkg::MODE_UPDATE, 64'h1234_5600_0000_6261, 4'd0, 8'h44);
        add(lpht_pkg::MODE_INSERT, 64'h78, lpht_pkg::CAT_DELETED, 8'h55); // stored as deleted
        add(lpht_pkg::MODE_UPDATE, 64'h78, 4'd0, 8'h56);
        add(lpht_pkg::MODE_INSERT, 64'h78, 4'd6, 8'h57);          // deleted slot with same name
        add(lpht_pkg::MODE_INSERT, 64'h71, lpht_pkg::CAT_EMPTY, 8'h66);   // stored as empty
        add(lpht_pkg::MODE_UPDATE, 64'h71, 4'd0, 8'h67);
        add(lpht_pkg::MODE_INSERT, 64'h71, 4'd7, 8'h68);
        add(lpht_pkg::MODE_INSERT, twin_a, lpht_pkg::CAT_DELETED, 8'h77); // collision chain
        add(lpht_pkg::MODE_INSERT, twin_b, 4'd8, 8'h78);          // reuses the deleted slot
        add(lpht_pkg::MODE_UPDATE, twin_a, 4'd0, 8'h79);
        add(lpht_pkg::MODE_UPDATE, twin_b, 4'd0, 8'h7a);
        add(lpht_pkg::MODE_INSERT, twin_a, 4'd10, 8'h7b);
        add(lpht_pkg::MODE_UPDATE, 64'h8877_6655_4433_2211, 4'd15, 8'h00);
        name_pool.push_back(canon(abc));
        name_pool.push_back(canon(twin_a));
        name_pool.push_back(canon(twin_b));

        // Random requests: the table fills, then long probes and full passes dominate
        for (int k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 19);
            if (r < 9 || name_pool.size() == 0) begin
                nm = fresh_name();
                add(lpht_pkg::MODE_INSERT, nm, pick_cat(), CHAN_W'($urandom));
                if (name_pool.size() < 400) name_pool.push_back(canon(nm));
            end else if (r < 19) begin
                nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
                if ($urandom_range(0, 1) == 0) nm = with_tail(nm);
                add(r < 14 ? lpht_pkg::MODE_UPDATE : lpht_pkg::MODE_INSERT, nm, pick_cat(),
                    CHAN_W'($urandom));
            end else begin
                add(lpht_pkg::MODE_UPDATE, fresh_name(), CAT_W'($urandom), CHAN_W'($urandom));
            end
            if (k == 500 || k == 1100) req_q[req_q.size() - 1].drain = 1'b1;
            if (k >= N_RANDOM - N_CALM_TAIL) req_q[req_q.size() - 1].calm = 1'b1;
        end

        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || s_axis_tvalid || n_recv != n_sent) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (due_q.size() != 0) begin
            $error("%0d results never arrived", due_q.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("linear_probe_hash_table_core: match");
        end else begin
            $display("linear_probe_hash_table_core: mismatch");
        end
        $finish;
    end

endmodule
